FILE: hdl/lad_pkg.sv
// package for the latency aware domain learner: field widths, codes,
// zone entry layout, sequencer states and register reset values
// no dependencies
package lad_pkg;

   // fixed field widths
   localparam int CMD_W  = 2;
   localparam int DRV_FW = 2;
   localparam int ZONE_W = 10;
   localparam int LAT_W  = 32;
   localparam int CNT_W  = 32;
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 8;

   // default sizing
   localparam int NUM_DRIVES_DEF      = 4;
   localparam int ZONES_PER_DRIVE_DEF = 1024;

   // divider: one quotient bit per step
   localparam int DIV_STEPS = LAT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // command codes
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TAG    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UNTAG  = 2'd2;

   // register indexes
   localparam logic [CSR_IW-1:0] CSR_SINGLE = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_THRESH = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_CONF   = 2'd2;

   // register reset values
   localparam logic       SINGLE_RST = 1'b0;
   localparam logic [7:0] THRESH_RST = 8'd4;
   localparam logic [7:0] CONF_RST   = 8'd4;

   // slow sample factor against the running mean
   localparam logic [2:0] LAT_FACTOR = 3'd5;

   typedef struct packed {
      logic              domain;
      logic [7:0]        conf;
      logic signed [7:0] vote;
      logic [7:0]        score;
   } zone_entry_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_Z,
      S_RD_G,
      S_EVAL,
      S_WR_Z,
      S_WR_G,
      S_DIV,
      S_FIN
   } state_type;

endpackage

FILE: hdl/latency_aware_domain_learner.sv
// latency aware domain learner top level: zone state memory, per-drive
// registers, sequencer and shared restoring divider for the running mean
// depends on lad_pkg
//
//  channel  ports                                   direction  handshake
//  request  start, busy, req_command/drive/zone/latency  in    start && !busy
//  response rsp_valid, rsp_zone_domain/flipped/
//           rsp_gc_active/rsp_mean_latency          out        rsp_valid strobe
//  config   csr_valid, csr_ready, csr_index, csr_wdata in      valid && ready
//
// a latency sample runs the read, evaluate and write states, then the 32 step
// restoring divider for the mean update (one quotient bit a cycle)
// tag, untag and unknown commands skip the divider, out of range items go
// straight to the response; after reset the zone memory is cleared one entry
// a cycle with busy held high
// the response strobe lasts one cycle and cannot be stalled by the receiver
// config writes are taken any time; csr_ready is always high
module latency_aware_domain_learner
   import lad_pkg::*;
#(
   parameter int NUM_DRIVES      = NUM_DRIVES_DEF,
   parameter int ZONES_PER_DRIVE = ZONES_PER_DRIVE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request transaction
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [DRV_FW-1:0] req_drive,
   input  logic [ZONE_W-1:0] req_zone,
   input  logic [LAT_W-1:0]  req_latency,
   // response transaction
   output logic              rsp_valid,
   output logic              rsp_zone_domain,
   output logic              rsp_flipped,
   output logic              rsp_gc_active,
   output logic [LAT_W-1:0]  rsp_mean_latency,
   // config write transaction
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   localparam int TOTAL_ZONES = NUM_DRIVES * ZONES_PER_DRIVE;
   localparam int ADDR_W      = $clog2(TOTAL_ZONES);
   localparam int DRV_W       = (NUM_DRIVES > 1) ? $clog2(NUM_DRIVES) : 1;
   localparam int ZCNT_W      = $clog2(ZONES_PER_DRIVE);
   localparam logic [ADDR_W-1:0]    ADDR_LAST = ADDR_W'(TOTAL_ZONES - 1);
   localparam logic [ZCNT_W-1:0]    ZONE_LAST = ZCNT_W'(ZONES_PER_DRIVE - 1);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(DIV_STEPS - 1);

   // ---------------------------------------------------------------------
   // config registers
   // ---------------------------------------------------------------------
   logic       single_ff, single_in;
   logic [7:0] thresh_ff, thresh_in;
   logic [7:0] cstart_ff, cstart_in;

   assign csr_ready = 1'b1;

   always_comb begin
      single_in = single_ff;
      thresh_in = thresh_ff;
      cstart_in = cstart_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SINGLE: single_in = csr_wdata[0];
            CSR_THRESH: thresh_in = csr_wdata;
            CSR_CONF:   cstart_in = csr_wdata;
            default:    ; // writes past the register list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         single_ff <= SINGLE_RST;
         thresh_ff <= THRESH_RST;
         cstart_ff <= CONF_RST;
      end else begin
         single_ff <= single_in;
         thresh_ff <= thresh_in;
         cstart_ff <= cstart_in;
      end
   end

   // ---------------------------------------------------------------------
   // sequencer state and control registers
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [ZCNT_W-1:0]    clr_zone_ff, clr_zone_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 drv_ok_ff, drv_ok_in;
   logic                 zone_ok_ff, zone_ok_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // per-drive state
   logic [LAT_W-1:0]  mean_ff     [NUM_DRIVES];
   logic [LAT_W-1:0]  mean_in     [NUM_DRIVES];
   logic [CNT_W-1:0]  cnt_ff      [NUM_DRIVES];
   logic [CNT_W-1:0]  cnt_in      [NUM_DRIVES];
   logic [ZONE_W-1:0] dest_ff     [NUM_DRIVES];
   logic [ZONE_W-1:0] dest_in     [NUM_DRIVES];
   logic              dest_vld_ff [NUM_DRIVES];
   logic              dest_vld_in [NUM_DRIVES];

   // latched request and working registers
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [DRV_W-1:0]  drv_ff, drv_in;
   logic [ZONE_W-1:0] zone_ff, zone_in;
   logic [LAT_W-1:0]  lat_ff, lat_in;
   logic [ADDR_W-1:0] z_addr_ff, z_addr_in;
   logic [ADDR_W-1:0] g_addr_ff, g_addr_in;
   zone_entry_type    zw_ff, zw_in;
   zone_entry_type    gw_ff, gw_in;
   logic              flip_ff, flip_in;

   // divider registers
   logic [LAT_W-1:0]  rem_ff, rem_in;
   logic [LAT_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic              neg_ff, neg_in;

   // response registers
   logic              rsp_dom_ff, rsp_dom_in;
   logic              rsp_flip_ff, rsp_flip_in;
   logic              rsp_gc_ff, rsp_gc_in;
   logic [LAT_W-1:0]  rsp_mean_ff, rsp_mean_in;

   // zone memory port
   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   zone_entry_type    mem_wdata;
   zone_entry_type    rd_data_ff;
   zone_entry_type    zone_mem [TOTAL_ZONES];

   logic accept;
   logic is_sample;
   logic sample_ok;

   assign accept    = start && !busy;
   assign is_sample = (cmd_ff == CMD_SAMPLE);
   assign sample_ok = drv_ok_ff && zone_ok_ff && is_sample;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_addr_ff == ADDR_LAST) state_in = S_IDLE;
         S_IDLE: begin
            if (accept) begin
               if (drv_ok_in && zone_ok_in) state_in = S_RD_Z;
               else state_in = S_FIN;
            end
         end
         S_RD_Z:  state_in = S_RD_G;
         S_RD_G:  state_in = S_EVAL;
         S_EVAL:  state_in = S_WR_Z;
         S_WR_Z:  state_in = S_WR_G;
         S_WR_G:  state_in = is_sample ? S_DIV : S_FIN;
         S_DIV:   if (div_cnt_ff == DIV_LAST) state_in = S_FIN;
         S_FIN:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs: busy and zone memory port
   always_comb begin
      busy      = 1'b1;
      mem_we    = 1'b0;
      mem_addr  = z_addr_ff;
      mem_wdata = zw_ff;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we           = 1'b1;
            mem_addr         = clr_addr_ff;
            mem_wdata.domain = clr_zone_ff[0];
            mem_wdata.conf   = CONF_RST;
            mem_wdata.vote   = '0;
            mem_wdata.score  = '0;
         end
         S_IDLE: busy = 1'b0;
         S_RD_Z: mem_addr = z_addr_ff;
         S_RD_G: mem_addr = g_addr_ff;
         S_WR_Z: begin
            mem_we   = is_sample;
            mem_addr = z_addr_ff;
         end
         S_WR_G: begin
            mem_we    = flip_ff;
            mem_addr  = g_addr_ff;
            mem_wdata = gw_ff;
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // datapath
   // ---------------------------------------------------------------------
   function automatic logic signed [7:0] vote_step(logic signed [7:0] v, logic up);
      logic signed [7:0] r;
      r = v;
      if (up && v != 8'sd127) r = v + 8'sd1;
      else if (!up && v != -8'sd128) r = v - 8'sd1;
      return r;
   endfunction

   // confidence down by one; at zero the domain follows the vote sign
   function automatic zone_entry_type conf_dec_check(zone_entry_type e,
                                                     logic [7:0] cs);
      zone_entry_type r;
      r = e;
      if (r.conf != 8'd0) r.conf = r.conf - 8'd1;
      if (r.conf == 8'd0) begin
         r.domain = (r.vote > 8'sd0);
         r.conf   = cs;
         r.vote   = '0;
      end
      return r;
   endfunction

   logic [31:0]       drv_ext;
   logic [31:0]       z_addr_ext;
   logic [31:0]       g_addr_ext;
   logic [LAT_W-1:0]  cur_mean;
   logic [LAT_W+2:0]  mean_x5;
   logic              hot;
   logic              active;
   zone_entry_type    z_new;
   zone_entry_type    g_new;
   logic              flip_new;
   logic [LAT_W:0]    diff;
   logic [LAT_W:0]    diff_mag;
   logic [CNT_W-1:0]  cnt_new;
   logic [LAT_W:0]    rem_sh;
   logic              rem_ge;
   logic [LAT_W-1:0]  quo_signed;
   logic [LAT_W-1:0]  mean_res;

   assign drv_ext    = 32'(req_drive);
   assign z_addr_ext = drv_ext * 32'(ZONES_PER_DRIVE) + 32'(req_zone);
   assign g_addr_ext = 32'(drv_ff) * 32'(ZONES_PER_DRIVE) + 32'(dest_ff[drv_ff]);
   assign cur_mean   = mean_ff[drv_ff];

   // slow sample test: latency above five times the running mean
   assign mean_x5 = ({3'b000, cur_mean} << 2) + {3'b000, cur_mean};
   assign hot     = {3'b000, lat_ff} > mean_x5;
   assign active  = is_sample && !single_ff && dest_vld_ff[drv_ff];

   // zone update, z from zw_ff and destination g from the read port
   always_comb begin
      z_new    = zw_ff;
      g_new    = rd_data_ff;
      flip_new = 1'b0;
      if (active && hot && (rd_data_ff.domain != zw_ff.domain)) begin
         if (z_new.score != 8'd255) z_new.score = z_new.score + 8'd1;
         if (z_new.score >= thresh_ff) begin
            flip_new     = 1'b1;
            z_new.domain = !z_new.domain;
            // the flipped zone votes away from its new domain, the
            // destination votes toward it
            z_new.vote = vote_step(z_new.vote, !z_new.domain);
            g_new.vote = vote_step(g_new.vote, z_new.domain);
            z_new      = conf_dec_check(z_new, cstart_ff);
            g_new      = conf_dec_check(g_new, cstart_ff);
            z_new.score = '0;
         end
      end
      if (active && z_new.score != 8'd0) z_new.score = z_new.score - 8'd1;
   end

   // divider setup: signed difference and saturating sample count
   assign diff     = {1'b0, lat_ff} - {1'b0, cur_mean};
   assign diff_mag = diff[LAT_W] ? (~diff + 1'b1) : diff;
   assign cnt_new  = (cnt_ff[drv_ff] == '1) ? cnt_ff[drv_ff] : cnt_ff[drv_ff] + 1'b1;

   // one restoring step a cycle
   assign rem_sh = {rem_ff, quo_ff[LAT_W-1]};
   assign rem_ge = rem_sh >= {1'b0, dvs_ff};

   assign quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign mean_res   = sample_ok ? cur_mean + quo_signed : cur_mean;

   always_comb begin
      clr_addr_in  = clr_addr_ff;
      clr_zone_in  = clr_zone_ff;
      div_cnt_in   = div_cnt_ff;
      drv_ok_in    = drv_ok_ff;
      zone_ok_in   = zone_ok_ff;
      rsp_valid_in = (state_ff == S_FIN);
      mean_in      = mean_ff;
      cnt_in       = cnt_ff;
      dest_in      = dest_ff;
      dest_vld_in  = dest_vld_ff;
      cmd_in       = cmd_ff;
      drv_in       = drv_ff;
      zone_in      = zone_ff;
      lat_in       = lat_ff;
      z_addr_in    = z_addr_ff;
      g_addr_in    = g_addr_ff;
      zw_in        = zw_ff;
      gw_in        = gw_ff;
      flip_in      = flip_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      rsp_dom_in   = rsp_dom_ff;
      rsp_flip_in  = rsp_flip_ff;
      rsp_gc_in    = rsp_gc_ff;
      rsp_mean_in  = rsp_mean_ff;

      case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            clr_zone_in = (clr_zone_ff == ZONE_LAST) ? '0 : clr_zone_ff + 1'b1;
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in     = req_command;
               drv_in     = drv_ext[DRV_W-1:0];
               zone_in    = req_zone;
               lat_in     = req_latency;
               z_addr_in  = z_addr_ext[ADDR_W-1:0];
               drv_ok_in  = drv_ext < 32'(NUM_DRIVES);
               zone_ok_in = 32'(req_zone) < 32'(ZONES_PER_DRIVE);
               flip_in    = 1'b0;
            end
         end
         S_RD_Z: g_addr_in = g_addr_ext[ADDR_W-1:0];
         S_RD_G: zw_in = rd_data_ff;
         S_EVAL: begin
            zw_in   = z_new;
            gw_in   = g_new;
            flip_in = flip_new;
            case (cmd_ff)
               CMD_TAG: begin
                  dest_in[drv_ff]     = zone_ff;
                  dest_vld_in[drv_ff] = 1'b1;
               end
               CMD_UNTAG: begin
                  if (dest_vld_ff[drv_ff] && dest_ff[drv_ff] == zone_ff)
                     dest_vld_in[drv_ff] = 1'b0;
               end
               default: ;
            endcase
         end
         S_WR_G: begin
            if (is_sample) begin
               cnt_in[drv_ff] = cnt_new;
               dvs_in         = cnt_new;
               neg_in         = diff[LAT_W];
               quo_in         = diff_mag[LAT_W-1:0];
               rem_in         = '0;
               div_cnt_in     = '0;
            end
         end
         S_DIV: begin
            rem_in     = rem_ge ? LAT_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[LAT_W-1:0];
            quo_in     = {quo_ff[LAT_W-2:0], rem_ge};
            div_cnt_in = div_cnt_ff + 1'b1;
         end
         S_FIN: begin
            if (sample_ok) mean_in[drv_ff] = mean_res;
            rsp_dom_in  = drv_ok_ff && zone_ok_ff && zw_ff.domain;
            rsp_flip_in = drv_ok_ff && zone_ok_ff && flip_ff;
            rsp_gc_in   = drv_ok_ff ? dest_vld_ff[drv_ff] : 1'b0;
            rsp_mean_in = drv_ok_ff ? mean_res : '0;
         end
         default: ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         clr_zone_ff  <= '0;
         div_cnt_ff   <= '0;
         drv_ok_ff    <= 1'b0;
         zone_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_DRIVES; i++) begin
            mean_ff[i]     <= '0;
            cnt_ff[i]      <= '0;
            dest_ff[i]     <= '0;
            dest_vld_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_zone_ff  <= clr_zone_in;
         div_cnt_ff   <= div_cnt_in;
         drv_ok_ff    <= drv_ok_in;
         zone_ok_ff   <= zone_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         mean_ff      <= mean_in;
         cnt_ff       <= cnt_in;
         dest_ff      <= dest_in;
         dest_vld_ff  <= dest_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      drv_ff      <= drv_in;
      zone_ff     <= zone_in;
      lat_ff      <= lat_in;
      z_addr_ff   <= z_addr_in;
      g_addr_ff   <= g_addr_in;
      zw_ff       <= zw_in;
      gw_ff       <= gw_in;
      flip_ff     <= flip_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dvs_ff      <= dvs_in;
      neg_ff      <= neg_in;
      rsp_dom_ff  <= rsp_dom_in;
      rsp_flip_ff <= rsp_flip_in;
      rsp_gc_ff   <= rsp_gc_in;
      rsp_mean_ff <= rsp_mean_in;
   end

   // zone memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) zone_mem[mem_addr] <= mem_wdata;
      rd_data_ff <= zone_mem[mem_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_zone_domain  = rsp_dom_ff;
   assign rsp_flipped      = rsp_flip_ff;
   assign rsp_gc_active    = rsp_gc_ff;
   assign rsp_mean_latency = rsp_mean_ff;

`ifndef ASSERT_OFF
   // memory clearing keeps the block busy right after reset
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   // an accepted transaction makes the block busy
   a_busy_on_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after accept");

   // response strobe is one cycle and arrives when the sequencer is done
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");
`endif

endmodule

FILE: dv/tb.sv
// self-checking testbench for latency_aware_domain_learner: directed and random
// tag, untag and latency sample transactions checked against an in-bench learner
// depends on lad_pkg and the latency_aware_domain_learner rtl
`timescale 1ns / 1ps

module tb
   import lad_pkg::*;
();

   // command code the block ignores
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   // drive 3 is kept at a running mean of zero so every nonzero sample is slow,
   // drive 2 takes full range latencies, drives 0 and 1 mostly small ones
   localparam logic [DRV_FW-1:0] FAST_DRIVE = 2'd3;
   localparam logic [DRV_FW-1:0] WIDE_DRIVE = 2'd2;
   localparam int NZ = NUM_DRIVES_DEF * ZONES_PER_DRIVE_DEF;
   localparam int MAX_PRINTS = 40;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [DRV_FW-1:0] drv;
      logic [ZONE_W-1:0] zone;
      logic [LAT_W-1:0]  lat;
      int unsigned       gap;   // idle cycles before this transaction is offered
   } zone_cmd_type;

   typedef struct {
      logic             dom;
      logic             flip;
      logic             gc;
      logic [LAT_W-1:0] mean;
   } zone_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [CMD_W-1:0]  req_command = '0;
   logic [DRV_FW-1:0] req_drive = '0;
   logic [ZONE_W-1:0] req_zone = '0;
   logic [LAT_W-1:0]  req_latency = '0;
   logic              rsp_valid;
   logic              rsp_zone_domain;
   logic              rsp_flipped;
   logic              rsp_gc_active;
   logic [LAT_W-1:0]  rsp_mean_latency;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   latency_aware_domain_learner DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_drive        (req_drive),
      .req_zone         (req_zone),
      .req_latency      (req_latency),
      .rsp_valid        (rsp_valid),
      .rsp_zone_domain  (rsp_zone_domain),
      .rsp_flipped      (rsp_flipped),
      .rsp_gc_active    (rsp_gc_active),
      .rsp_mean_latency (rsp_mean_latency),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // learner state as the block should hold it
   // ---------------------------------------------------------------------
   logic              dom_of   [0:NZ-1];
   logic [7:0]        conf_of  [0:NZ-1];
   logic signed [7:0] votes_of [0:NZ-1];
   logic [7:0]        heat_of  [0:NZ-1];   // high latency score
   logic [LAT_W-1:0]  drive_mean [0:NUM_DRIVES_DEF-1];
   logic [CNT_W-1:0]  drive_hits [0:NUM_DRIVES_DEF-1];
   logic [ZONE_W-1:0] gc_dest    [0:NUM_DRIVES_DEF-1];
   logic              gc_armed   [0:NUM_DRIVES_DEF-1];
   // register copies
   logic              one_domain;
   logic [7:0]        flip_at;
   logic [7:0]        conf_reload;

   zone_cmd_type    zone_cmds [$];     // transactions waiting for the driver
   zone_result_type results_due [$];   // predicted responses, oldest first

   // stimulus shaping
   int unsigned       sender_idle_pct = 0;
   logic              burst_calm = 1'b1;
   logic              anchor_on = 1'b0;
   logic [ZONE_W-1:0] anchor_zone = '0;

   // bookkeeping
   int unsigned mismatches = 0;
   int unsigned checked = 0;
   int unsigned flips_seen = 0;
   int unsigned sent_by_cmd [0:3] = '{0, 0, 0, 0};
   logic        req_taken = 1'b0;
   int unsigned gap_count = 0;
   zone_cmd_type    next_cmd;
   zone_cmd_type    seen_cmd;
   zone_result_type due;

   function automatic void reset_learner();
      for (int i = 0; i < NZ; i++) begin
         dom_of[i]   = i[0];   // low bit of the zone index
         conf_of[i]  = CONF_RST;
         votes_of[i] = '0;
         heat_of[i]  = '0;
      end
      for (int d = 0; d < NUM_DRIVES_DEF; d++) begin
         drive_mean[d] = '0;
         drive_hits[d] = '0;
         gc_dest[d]    = '0;
         gc_armed[d]   = 1'b0;
      end
      one_domain  = SINGLE_RST;
      flip_at     = THRESH_RST;
      conf_reload = CONF_RST;
   endfunction

   function automatic logic signed [7:0] nudge_vote(logic signed [7:0] v, logic up);
      if (up)
         return (v == 8'sd127) ? v : v + 8'sd1;
      return (v == -8'sd128) ? v : v - 8'sd1;
   endfunction

   // confidence drain; at zero the domain is re-decided by the vote sign
   function automatic void drain_confidence(logic [11:0] z);
      if (conf_of[z] != 8'd0)
         conf_of[z] = conf_of[z] - 8'd1;
      if (conf_of[z] == 8'd0) begin
         dom_of[z]   = (votes_of[z] > 0);
         conf_of[z]  = conf_reload;
         votes_of[z] = '0;
      end
   endfunction

   // running mean: signed difference over the saturating sample count
   function automatic void advance_mean(logic [DRV_FW-1:0] d, logic [LAT_W-1:0] lat);
      longint delta;
      if (drive_hits[d] != '1)
         drive_hits[d] = drive_hits[d] + 1'b1;
      delta = $signed({32'd0, lat}) - $signed({32'd0, drive_mean[d]});
      delta = delta / $signed({32'd0, drive_hits[d]});
      drive_mean[d] = drive_mean[d] + delta[31:0];
   endfunction

   // applies one transaction to the learner state and returns the response
   function automatic zone_result_type learn_zone_step(zone_cmd_type c);
      zone_result_type r;
      logic [11:0]     z;
      logic [11:0]     g;
      r.flip = 1'b0;
      z = {c.drv, c.zone};
      case (c.cmd)
         CMD_SAMPLE: begin
            if (!one_domain && gc_armed[c.drv]) begin
               g = {c.drv, gc_dest[c.drv]};
               if ({32'd0, c.lat} > {61'd0, LAT_FACTOR} * {32'd0, drive_mean[c.drv]} &&
                   dom_of[g] != dom_of[z]) begin
                  if (heat_of[z] != 8'hFF)
                     heat_of[z] = heat_of[z] + 8'd1;
                  if (heat_of[z] >= flip_at) begin
                     r.flip    = 1'b1;
                     dom_of[z] = ~dom_of[z];
                     // the slow zone votes against its new domain, the destination for it
                     votes_of[z] = nudge_vote(votes_of[z], ~dom_of[z]);
                     votes_of[g] = nudge_vote(votes_of[g], dom_of[z]);
                     drain_confidence(z);
                     drain_confidence(g);
                     heat_of[z] = '0;
                  end
               end
               if (heat_of[z] != 8'd0)
                  heat_of[z] = heat_of[z] - 8'd1;
            end
            advance_mean(c.drv, c.lat);
         end
         CMD_TAG: begin
            gc_dest[c.drv]  = c.zone;
            gc_armed[c.drv] = 1'b1;
         end
         CMD_UNTAG: begin
            // only the tagged destination itself clears the tag
            if (gc_armed[c.drv] && gc_dest[c.drv] == c.zone)
               gc_armed[c.drv] = 1'b0;
         end
         default: ;
      endcase
      r.dom  = dom_of[z];
      r.gc   = gc_armed[c.drv];
      r.mean = drive_mean[c.drv];
      return r;
   endfunction

   task automatic flag_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("tb: mismatch at %0t: %s", $realtime, what);
   endtask

   // ---------------------------------------------------------------------
   // driver: offers queued transactions at the falling edge
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_count = 0;
      end else if (!start || req_taken) begin
         if (zone_cmds.size() != 0 && gap_count < zone_cmds[0].gap) begin
            // sender idle cycle
            gap_count++;
            start <= 1'b0;
         end else if (zone_cmds.size() != 0) begin
            next_cmd = zone_cmds.pop_front();
            gap_count = 0;
            req_command <= next_cmd.cmd;
            req_drive   <= next_cmd.drv;
            req_zone    <= next_cmd.zone;
            req_latency <= next_cmd.lat;
            start       <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: checks responses, tracks register writes, predicts accepted
   // transactions; all at the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (results_due.size() == 0) begin
               flag_mismatch("response with no transaction outstanding");
            end else begin
               due = results_due.pop_front();
               checked++;
               if (rsp_zone_domain !== due.dom)
                  flag_mismatch($sformatf("rsp %0d zone_domain got %b want %b",
                                          checked, rsp_zone_domain, due.dom));
               if (rsp_flipped !== due.flip)
                  flag_mismatch($sformatf("rsp %0d flipped got %b want %b",
                                          checked, rsp_flipped, due.flip));
               if (rsp_gc_active !== due.gc)
                  flag_mismatch($sformatf("rsp %0d gc_active got %b want %b",
                                          checked, rsp_gc_active, due.gc));
               if (rsp_mean_latency !== due.mean)
                  flag_mismatch($sformatf("rsp %0d mean_latency got %0h want %0h",
                                          checked, rsp_mean_latency, due.mean));
               if (due.flip)
                  flips_seen++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SINGLE: one_domain  = csr_wdata[0];
               CSR_THRESH: flip_at     = csr_wdata;
               CSR_CONF:   conf_reload = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            seen_cmd.cmd  = req_command;
            seen_cmd.drv  = req_drive;
            seen_cmd.zone = req_zone;
            seen_cmd.lat  = req_latency;
            seen_cmd.gap  = 0;
            results_due.push_back(learn_zone_step(seen_cmd));
            sent_by_cmd[req_command]++;
         end
         req_taken <= start && !busy;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   function automatic void add_cmd(logic [CMD_W-1:0] cmd, logic [DRV_FW-1:0] drv,
                                   logic [ZONE_W-1:0] zn, logic [LAT_W-1:0] lat);
      zone_cmd_type it;
      it.cmd  = cmd;
      it.drv  = drv;
      it.zone = zn;
      it.lat  = lat;
      // long gaps so new transactions land on every cycle of the sample pipeline
      if (burst_calm || $urandom_range(1, 100) > sender_idle_pct)
         it.gap = 0;
      else
         it.gap = $urandom_range(1, 48);
      zone_cmds.push_back(it);
   endfunction

   function automatic logic [LAT_W-1:0] pick_latency(logic [DRV_FW-1:0] d);
      if (d == FAST_DRIVE)
         return $urandom_range(0, 1);   // below the sample count, mean stays zero
      if (d == WIDE_DRIVE)
         return ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 4095);
      // small baseline with occasional slow outliers
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5000, 1 << 20)
                                         : $urandom_range(0, 255);
   endfunction

   task automatic queue_directed();
      burst_calm = 1'b1;
      // fast drive: two zero samples pin the mean at zero
      add_cmd(CMD_SAMPLE,  FAST_DRIVE, 10'd5, 32'd0);
      add_cmd(CMD_SAMPLE,  FAST_DRIVE, 10'd6, 32'd0);
      add_cmd(CMD_UNKNOWN, 2'd0, 10'd0, 32'd0);
      add_cmd(CMD_UNTAG,   2'd1, 10'd7, 32'd0);          // nothing tagged
      add_cmd(CMD_TAG,     FAST_DRIVE, 10'd0, 32'd0);    // destination in domain 0
      add_cmd(CMD_SAMPLE,  FAST_DRIVE, 10'd1, 32'd1);    // slow, other domain: flip
      add_cmd(CMD_SAMPLE,  FAST_DRIVE, 10'd1, 32'd1);    // same domain now
      add_cmd(CMD_SAMPLE,  FAST_DRIVE, 10'd1023, 32'd1);
      add_cmd(CMD_TAG,     FAST_DRIVE, 10'd3, 32'd0);    // tag while tagged
      add_cmd(CMD_UNTAG,   FAST_DRIVE, 10'd0, 32'd0);    // untag of another zone
      add_cmd(CMD_SAMPLE,  FAST_DRIVE, 10'd0, 32'd1);
      add_cmd(CMD_SAMPLE,  FAST_DRIVE, 10'd2, 32'd0);    // not above the mean
      add_cmd(CMD_UNTAG,   FAST_DRIVE, 10'd3, 32'd0);
      add_cmd(CMD_SAMPLE,  FAST_DRIVE, 10'd2, 32'd1);    // no destination
      // latency extremes and the signed mean difference
      add_cmd(CMD_SAMPLE,  WIDE_DRIVE, 10'd0, 32'hFFFF_FFFF);
      add_cmd(CMD_SAMPLE,  WIDE_DRIVE, 10'd1023, 32'd0);
      add_cmd(CMD_TAG,     WIDE_DRIVE, 10'd1023, 32'hFFFF_FFFF);
      add_cmd(CMD_SAMPLE,  WIDE_DRIVE, 10'd0, 32'hFFFF_FFFF);
      add_cmd(CMD_TAG,     2'd1, 10'd512, 32'd0);
      add_cmd(CMD_SAMPLE,  2'd1, 10'd513, 32'hFFFF_FFFF);
      add_cmd(CMD_UNKNOWN, WIDE_DRIVE, 10'd1023, 32'hFFFF_FFFF);
      add_cmd(CMD_SAMPLE,  WIDE_DRIVE, 10'd0, 32'hAAAA_AAAA);
      add_cmd(CMD_SAMPLE,  WIDE_DRIVE, 10'd1, 32'h5555_5555);
      add_cmd(CMD_UNTAG,   2'd1, 10'd512, 32'd0);
   endtask

   // bursts per drive: usually a tag, then samples over a small zone set mixed
   // with retags, untags, ignored commands and full range noise
   task automatic queue_random(int unsigned n);
      int unsigned       made;
      int unsigned       len;
      int unsigned       r;
      logic [DRV_FW-1:0] d;
      logic [ZONE_W-1:0] dest;
      logic [ZONE_W-1:0] zn;
      logic [ZONE_W-1:0] pool [0:5];
      logic              fresh;
      made = 0;
      while (made < n) begin
         if (anchor_on && $urandom_range(0, 99) < 85)
            d = FAST_DRIVE;
         else
            d = DRV_FW'($urandom_range(0, 3));
         burst_calm = ($urandom_range(0, 3) == 0);
         // anchored bursts keep one destination so its vote runs to the limits
         fresh = anchor_on && d == FAST_DRIVE;
         dest = fresh ? anchor_zone : ZONE_W'($urandom_range(0, 1023));
         foreach (pool[p])
            pool[p] = ZONE_W'($urandom_range(0, 1023));
         if (fresh || $urandom_range(0, 9) < 8) begin
            add_cmd(CMD_TAG, d, dest, $urandom());
            made++;
         end
         len = $urandom_range(4, 24);
         for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 82) begin
               if (fresh || $urandom_range(0, 9) < 3)
                  zn = ZONE_W'($urandom_range(0, 1023));
               else
                  zn = pool[$urandom_range(0, 5)];
               add_cmd(CMD_SAMPLE, d, zn, pick_latency(d));
               made++;
            end else if (r < 87) begin
               dest = ZONE_W'($urandom_range(0, 1023));
               add_cmd(CMD_TAG, d, dest, $urandom());
               made++;
            end else if (r < 93) begin
               zn = $urandom_range(0, 1) ? dest : ZONE_W'($urandom_range(0, 1023));
               add_cmd(CMD_UNTAG, d, zn, $urandom());
               made++;
            end else if (r < 96) begin
               add_cmd(CMD_UNKNOWN, DRV_FW'($urandom_range(0, 3)),
                       ZONE_W'($urandom_range(0, 1023)), $urandom());
            end else begin
               add_cmd(CMD_SAMPLE, WIDE_DRIVE, ZONE_W'($urandom_range(0, 1023)),
                       $urandom());
               made++;
            end
         end
         if ($urandom_range(0, 2) == 0) begin
            add_cmd(CMD_UNTAG, d, dest, $urandom());
            made++;
         end
      end
   endtask

   // everything sent, answered, and the block idle
   task automatic wait_drained();
      do @(negedge clock);
      while (zone_cmds.size() != 0 || start || results_due.size() != 0 || busy !== 1'b0);
   endtask

   task automatic write_reg(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock);
      while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // registers change only between phases with the block idle
   task automatic set_phase(logic single, logic [7:0] thresh, logic [7:0] conf,
                            int unsigned idle, logic anchored, logic [ZONE_W-1:0] anchor);
      wait_drained();
      write_reg(CSR_SINGLE, {7'd0, single});
      write_reg(CSR_THRESH, thresh);
      write_reg(CSR_CONF, conf);
      @(posedge clock);
      sender_idle_pct = idle;
      anchor_on       = anchored;
      anchor_zone     = anchor;
   endtask

   initial begin
      reset_learner();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // the first drain also waits out the zone clearing pass after reset
      set_phase(1'b0, 8'd1, 8'd4, 0, 1'b0, '0);
      queue_directed();
      // vote of an odd destination climbs to its upper limit
      set_phase(1'b0, 8'd1, 8'd255, 0, 1'b1, 10'd1001);
      queue_random(600);
      // one domain: only the means move
      set_phase(1'b1, 8'd1, 8'd1, 83, 1'b0, '0);
      queue_random(250);
      // confidence reload of one: once reloaded, a zone is re-decided on every flip
      set_phase(1'b0, 8'd1, 8'd1, 6, 1'b0, '0);
      queue_random(300);
      // threshold out of reach: no flips
      set_phase(1'b0, 8'd255, 8'd128, 83, 1'b0, '0);
      queue_random(200);
      // even destination drives its vote to the lower limit
      set_phase(1'b0, 8'd1, 8'd255, 6, 1'b1, 10'd2);
      queue_random(480);
      wait_drained();
      // room for a stray response after the last one
      repeat (50) @(posedge clock);
      if (results_due.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", results_due.size()));
      $display("tb: %0d responses checked (%0d samples, %0d tags, %0d untags, %0d ignored)",
               checked, sent_by_cmd[CMD_SAMPLE], sent_by_cmd[CMD_TAG],
               sent_by_cmd[CMD_UNTAG], sent_by_cmd[CMD_UNKNOWN]);
      $display("tb: %0d domain flips over six register settings, %0d mismatches",
               flips_seen, mismatches);
      if (mismatches == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule
